// ----- hdl/tsp_permutation_range_search_assert.svh -----
// Assertion macros for the permutation range search block.
`ifndef TSP_PERMUTATION_RANGE_SEARCH_ASSERT_SVH
`define TSP_PERMUTATION_RANGE_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSPRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSPRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tsprs_pkg.sv -----
// Package: types, constants and factorial table for the permutation range search.
package tsprs_pkg;

    localparam int MAX_CITIES_DEF = 16;
    localparam int CITY_W         = 4;
    localparam int WEIGHT_W       = 16;
    localparam int COST_W         = 20;
    localparam int TOTAL_W        = 21;
    localparam int RANK_W         = 41;
    localparam int CCOUNT_W       = 5;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 64;

    typedef logic [CITY_W-1:0] t_city;

    typedef enum logic [1:0] {
        REG_CITY_COUNT = 2'd0,
        REG_FIRST_RANK = 2'd1,
        REG_RANK_COUNT = 2'd2
    } t_reg;

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_RUN   = 1'b1
    } t_action;

    typedef struct packed {
        logic                action;
        logic [CITY_W-1:0]   to_city;
        logic [CITY_W-1:0]   from_city;
        logic [WEIGHT_W-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [COST_W-1:0] best_cost;
        logic [CITY_W-1:0] city;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOAD,
        ST_DIGIT,
        ST_COST,
        ST_DRAIN,
        ST_CMP,
        ST_OUT
    } t_state;

    function automatic logic [RANK_W-1:0] fact(input logic [3:0] idx);
        logic [RANK_W-1:0] f;
        unique case (idx)
            4'd0:  f = 41'd1;
            4'd1:  f = 41'd1;
            4'd2:  f = 41'd2;
            4'd3:  f = 41'd6;
            4'd4:  f = 41'd24;
            4'd5:  f = 41'd120;
            4'd6:  f = 41'd720;
            4'd7:  f = 41'd5040;
            4'd8:  f = 41'd40320;
            4'd9:  f = 41'd362880;
            4'd10: f = 41'd3628800;
            4'd11: f = 41'd39916800;
            4'd12: f = 41'd479001600;
            4'd13: f = 41'd6227020800;
            4'd14: f = 41'd87178291200;
            default: f = 41'd1307674368000;
        endcase
        return f;
    endfunction

endpackage

// ----- hdl/tsprs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsprs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tsp_permutation_range_search.sv -----
// Top level: brute-force tour search over a range of city orderings.
// Weight write: one transaction per cycle while idle, no result.
// Run: start-rank reduction, then per ordering up to about N*N/2 unrank
// subtract steps plus weight-table reads through one RAM read port,
// then N+1 result transactions; input is not ready from run start to last result.
// Reset is synchronous active low: idle, registers at defaults, weight table unset.
module tsp_permutation_range_search #(
    parameter int MAX_CITIES = tsprs_pkg::MAX_CITIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tsprs_pkg::t_in_item                i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tsprs_pkg::t_out_item               o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsprs_pkg::APB_AW-1:0]       paddr,
    input  logic [tsprs_pkg::APB_DW-1:0]       pwdata,
    output logic [tsprs_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);

    localparam int CIW = $clog2(MAX_CITIES);
    localparam int KW  = $clog2(MAX_CITIES + 1);
    localparam int AW  = $clog2(MAX_CITIES * MAX_CITIES);
    localparam int OD  = MAX_CITIES - 1;
    localparam int RW  = tsprs_pkg::RANK_W;
    localparam int CW  = tsprs_pkg::CITY_W;

    tsprs_pkg::t_state r_state, n_state;

    logic [tsprs_pkg::CCOUNT_W-1:0] r_city_count;
    logic [RW-1:0] r_first_rank, r_rank_count;
    logic [CIW-1:0] r_m, n_m;
    logic [RW-1:0] r_cnt_lim, n_cnt_lim, r_cnt, n_cnt, r_rank, n_rank;
    logic [RW-1:0] r_acc, n_acc, r_rem, n_rem, r_res, n_res;
    logic [5:0] r_bit, n_bit;
    logic [CIW-1:0] r_i, n_i, r_d, n_d, r_pos, n_pos;
    logic [CW-1:0] r_pool [OD];
    logic [CW-1:0] n_pool [OD];
    logic [CW-1:0] r_order [OD];
    logic [CW-1:0] n_order [OD];
    logic [CW-1:0] r_best_order [OD];
    logic [CW-1:0] n_best_order [OD];
    logic [tsprs_pkg::TOTAL_W-1:0] r_best, n_best;
    logic [tsprs_pkg::COST_W-1:0] r_sum, n_sum;
    logic [CW-1:0] r_prev, n_prev;
    logic r_pend, n_pend;
    logic [KW-1:0] r_k, n_k;

    logic cfg_we, in_acc, out_acc, ram_we;
    logic [tsprs_pkg::CCOUNT_W-1:0] n_clamp;
    logic [CIW-1:0] m_new, avail;
    logic [RW-1:0] f_new, f_sel, fr0, rank_inc;
    logic [RW:0] sub_a;
    logic [RW+1:0] diff;
    logic ge;
    logic [CW-1:0] next_city;
    logic [AW-1:0] waddr, raddr;
    logic [tsprs_pkg::WEIGHT_W-1:0] rdata;
    logic [CIW-1:0] k_idx;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= tsprs_pkg::CCOUNT_W'(4);
            r_first_rank <= RW'(1);
            r_rank_count <= RW'(1);
        end else if (cfg_we) begin
            unique case (paddr[4:3])
                tsprs_pkg::REG_CITY_COUNT: r_city_count <= pwdata[tsprs_pkg::CCOUNT_W-1:0];
                tsprs_pkg::REG_FIRST_RANK: r_first_rank <= pwdata[RW-1:0];
                tsprs_pkg::REG_RANK_COUNT: r_rank_count <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[4:3])
            tsprs_pkg::REG_CITY_COUNT: prdata = tsprs_pkg::APB_DW'(r_city_count);
            tsprs_pkg::REG_FIRST_RANK: prdata = tsprs_pkg::APB_DW'(r_first_rank);
            tsprs_pkg::REG_RANK_COUNT: prdata = tsprs_pkg::APB_DW'(r_rank_count);
            default: prdata = '0;
        endcase
    end

    assign o_in_ready  = (r_state == tsprs_pkg::ST_IDLE);
    assign o_out_valid = (r_state == tsprs_pkg::ST_OUT);
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_comb begin
        if (r_city_count < tsprs_pkg::CCOUNT_W'(2)) begin
            n_clamp = tsprs_pkg::CCOUNT_W'(2);
        end else if (r_city_count > tsprs_pkg::CCOUNT_W'(MAX_CITIES)) begin
            n_clamp = tsprs_pkg::CCOUNT_W'(MAX_CITIES);
        end else begin
            n_clamp = r_city_count;
        end
    end
    assign m_new = CIW'(n_clamp - 1'b1);
    assign f_new = tsprs_pkg::fact(4'(m_new));
    assign fr0   = (r_first_rank == '0) ? '0 : r_first_rank - 1'b1;
    assign avail = r_m - r_i;
    assign rank_inc = r_rank + 1'b1;

    // shared compare-subtract unit
    assign f_sel = (r_state == tsprs_pkg::ST_MOD) ? tsprs_pkg::fact(4'(r_m))
                                                  : tsprs_pkg::fact(4'(r_m - r_i - 1'b1));
    assign sub_a = (r_state == tsprs_pkg::ST_MOD) ? {r_rem, r_acc[RW-1]} : {1'b0, r_res};
    assign diff  = {1'b0, sub_a} - {2'b00, f_sel};
    assign ge    = !diff[RW+1];

    assign next_city = (r_pos < r_m) ? r_order[r_pos] : '0;
    assign raddr = AW'(next_city * MAX_CITIES + r_prev);
    assign waddr = AW'(i_in.to_city * MAX_CITIES + i_in.from_city);
    assign ram_we = in_acc && (i_in.action == tsprs_pkg::ACT_WRITE)
                    && ({1'b0, i_in.to_city} < (CW+1)'(MAX_CITIES))
                    && ({1'b0, i_in.from_city} < (CW+1)'(MAX_CITIES));

    tsprs_ram #(
        .WIDTH (tsprs_pkg::WEIGHT_W),
        .DEPTH (MAX_CITIES * MAX_CITIES)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_in.weight),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_m = r_m; n_cnt_lim = r_cnt_lim; n_cnt = r_cnt; n_rank = r_rank;
        n_acc = r_acc; n_rem = r_rem; n_res = r_res; n_bit = r_bit;
        n_i = r_i; n_d = r_d; n_pos = r_pos;
        n_pool = r_pool; n_order = r_order; n_best_order = r_best_order;
        n_best = r_best; n_sum = r_sum; n_prev = r_prev; n_pend = r_pend; n_k = r_k;
        unique case (r_state)
            tsprs_pkg::ST_IDLE: begin
                if (in_acc && i_in.action == tsprs_pkg::ACT_RUN) begin
                    n_m = m_new;
                    n_cnt = '0;
                    if (r_rank_count == '0) begin
                        n_cnt_lim = RW'(1);
                    end else if (r_rank_count > f_new) begin
                        n_cnt_lim = f_new;
                    end else begin
                        n_cnt_lim = r_rank_count;
                    end
                    n_best = '1;
                    n_acc = fr0;
                    n_rem = '0;
                    n_bit = 6'(RW);
                    n_state = tsprs_pkg::ST_MOD;
                end
            end
            tsprs_pkg::ST_MOD: begin
                n_rem = ge ? diff[RW-1:0] : sub_a[RW-1:0];
                n_acc = r_acc << 1;
                n_bit = r_bit - 1'b1;
                if (r_bit == 6'd1) begin
                    n_rank = n_rem;
                    n_state = tsprs_pkg::ST_LOAD;
                end
            end
            tsprs_pkg::ST_LOAD: begin
                n_res = r_rank;
                for (int p = 0; p < OD; p++) begin
                    n_pool[p] = CW'(p + 1);
                end
                n_i = '0;
                n_d = '0;
                n_state = tsprs_pkg::ST_DIGIT;
            end
            tsprs_pkg::ST_DIGIT: begin
                if (ge && (r_d < avail - 1'b1)) begin
                    n_res = diff[RW-1:0];
                    n_d = r_d + 1'b1;
                end else begin
                    n_order[r_i] = r_pool[r_d];
                    for (int p = 0; p < OD - 1; p++) begin
                        if (CIW'(p) >= r_d) begin
                            n_pool[p] = r_pool[p + 1];
                        end
                    end
                    n_i = r_i + 1'b1;
                    n_d = '0;
                    if (r_i == r_m - 1'b1) begin
                        n_pos = '0;
                        n_prev = '0;
                        n_sum = '0;
                        n_pend = 1'b0;
                        n_state = tsprs_pkg::ST_COST;
                    end
                end
            end
            tsprs_pkg::ST_COST: begin
                n_prev = next_city;
                n_pend = 1'b1;
                if (r_pend) begin
                    n_sum = r_sum + tsprs_pkg::COST_W'(rdata);
                end
                if (r_pos == r_m) begin
                    n_state = tsprs_pkg::ST_DRAIN;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            tsprs_pkg::ST_DRAIN: begin
                n_sum = r_sum + tsprs_pkg::COST_W'(rdata);
                n_state = tsprs_pkg::ST_CMP;
            end
            tsprs_pkg::ST_CMP: begin
                if ({1'b0, r_sum} < r_best) begin
                    n_best = {1'b0, r_sum};
                    n_best_order = r_order;
                end
                if (r_cnt == r_cnt_lim - 1'b1) begin
                    n_k = '0;
                    n_state = tsprs_pkg::ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_rank = (rank_inc == tsprs_pkg::fact(4'(r_m))) ? '0 : rank_inc;
                    n_state = tsprs_pkg::ST_LOAD;
                end
            end
            tsprs_pkg::ST_OUT: begin
                if (out_acc) begin
                    if (r_k == KW'(r_m) + 1'b1) begin
                        n_state = tsprs_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = tsprs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsprs_pkg::ST_IDLE;
            r_best  <= '1;
            r_cnt   <= '0;
            r_order <= '{default: '0};
            r_best_order <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_best  <= n_best;
            r_cnt   <= n_cnt;
            r_order <= n_order;
            r_best_order <= n_best_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m; r_cnt_lim <= n_cnt_lim; r_rank <= n_rank;
        r_acc <= n_acc; r_rem <= n_rem; r_res <= n_res; r_bit <= n_bit;
        r_i <= n_i; r_d <= n_d; r_pos <= n_pos; r_pool <= n_pool;
        r_sum <= n_sum; r_prev <= n_prev; r_pend <= n_pend; r_k <= n_k;
    end

    assign k_idx = CIW'(r_k - 1'b1);
    assign o_out.best_cost = r_best[tsprs_pkg::COST_W-1:0];
    assign o_out.city = ((r_k != '0) && (r_k <= KW'(r_m))) ? r_best_order[k_idx] : '0;
    assign o_out.last = (r_k == KW'(r_m) + 1'b1);

    `include "tsp_permutation_range_search_assert.svh"

    `TSPRS_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready while results pending")
    `TSPRS_ASSERT_NXT(a_last_frees_in, i_clk, i_rst_n, out_acc && o_out.last, o_in_ready, "block not idle after last result")
    `TSPRS_ASSERT_IMP(a_digit_bound, i_clk, i_rst_n, r_state == tsprs_pkg::ST_DIGIT, r_d < avail, "digit exceeds free cities")
    `TSPRS_ASSERT_NXT(a_run_resets_best, i_clk, i_rst_n, in_acc && i_in.action == tsprs_pkg::ACT_RUN, r_best == '1, "best cost not cleared at run start")

endmodule
